// ===== hdl/octs_pkg.sv =====
// ----------------------------------------------------------------------------
// octs_pkg
// Shared constants and types for the object cache tag store.
// ----------------------------------------------------------------------------
package octs_pkg;

    localparam int NUM_LINES = 16;
    localparam int LINE_W    = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int IDX_W     = 4;
    localparam int KEY_W     = 64;
    localparam int LEN_W     = 17;
    localparam int STAMP_W   = 32;

    localparam logic [LEN_W-1:0] MAX_OBJ_RESET = LEN_W'(102400);

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_FILL   = 1'b1;

    typedef logic [LINE_W-1:0] t_line_idx;

    // one entry of the line memory
    typedef struct packed {
        logic [KEY_W-1:0]   tag;
        logic [LEN_W-1:0]   len;
        logic [STAMP_W-1:0] stamp;
    } t_line;

    // command beat into the scan engine
    typedef struct packed {
        logic             start;
        logic             cmd;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
    } t_cmd;

    // result beat out of the scan engine
    typedef struct packed {
        logic             done;
        logic             hit;
        logic [IDX_W-1:0] line;
        logic [LEN_W-1:0] len;
        logic             filled;
    } t_result;

endpackage

// ===== hdl/octs_line_mem.sv =====
// ----------------------------------------------------------------------------
// octs_line_mem
// Line memory: tag, length and fill stamp per line, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module octs_line_mem
    import octs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_we,
    input  t_line_idx i_waddr,
    input  t_line     i_wdata,
    input  logic      i_re,
    input  t_line_idx i_raddr,
    output t_line     o_rdata
);

    t_line mem [NUM_LINES];
    t_line r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/octs_scan.sv =====
// ----------------------------------------------------------------------------
// octs_scan
// Sequencer that walks the line memory for lookups and oldest-stamp victim
// selection, holds the valid bits and the fill counter.
// ----------------------------------------------------------------------------
module octs_scan
    import octs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [LEN_W-1:0] i_max_obj,
    output logic             o_busy,
    output t_result          o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;

    localparam t_line_idx LAST = LINE_W'(NUM_LINES - 1);

    logic [1:0]             r_state, n_state;
    logic                   r_cmd, n_cmd;
    logic [KEY_W-1:0]       r_key, n_key;
    logic [LEN_W-1:0]       r_len, n_len;
    logic [NUM_LINES-1:0]   r_valid, n_valid;
    logic [STAMP_W-1:0]     r_fill_cnt, n_fill_cnt;
    t_line_idx              r_addr, n_addr;
    logic                   r_issue_done, n_issue_done;
    logic                   r_cmp_vld, n_cmp_vld;
    t_line_idx              r_cmp_idx, n_cmp_idx;
    logic [STAMP_W-1:0]     r_min_stamp, n_min_stamp;
    t_line_idx              r_min_idx, n_min_idx;
    t_result                r_res, n_res;

    logic      accept;
    logic      all_valid;
    t_line_idx first_free;
    logic      mem_we;
    t_line_idx mem_waddr;
    t_line     mem_wdata;
    logic      mem_re;
    t_line     mem_rdata;
    logic      match;
    logic      older;

    octs_line_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    assign o_busy    = (r_state != S_IDLE);
    assign accept    = i_cmd.start && (r_state == S_IDLE);
    assign all_valid = &r_valid;

    // lowest-numbered invalid line
    always_comb begin
        first_free = '0;
        for (int i = NUM_LINES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                first_free = LINE_W'(i);
            end
        end
    end

    assign match = r_valid[r_cmp_idx] && (mem_rdata.tag == r_key);
    // first compared line seeds the minimum; strict less keeps lowest index on ties
    assign older = (r_cmp_idx == '0) || (mem_rdata.stamp < r_min_stamp);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_len        = r_len;
        n_valid      = r_valid;
        n_fill_cnt   = r_fill_cnt;
        n_addr       = r_addr;
        n_issue_done = r_issue_done;
        n_cmp_vld    = 1'b0;
        n_cmp_idx    = r_addr;
        n_min_stamp  = r_min_stamp;
        n_min_idx    = r_min_idx;
        n_res        = '0;
        mem_we       = 1'b0;
        mem_waddr    = first_free;
        mem_wdata    = '{tag: i_cmd.key, len: i_cmd.len, stamp: r_fill_cnt + 1'b1};
        mem_re       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd        = i_cmd.cmd;
                    n_key        = i_cmd.key;
                    n_len        = i_cmd.len;
                    n_addr       = '0;
                    n_issue_done = 1'b0;
                    if (i_cmd.cmd == CMD_LOOKUP) begin
                        n_state = S_SCAN;
                    end else if (i_cmd.len > i_max_obj) begin
                        n_res.done = 1'b1;
                    end else if (!all_valid) begin
                        // free line: write it straight away
                        mem_we              = 1'b1;
                        n_valid[first_free] = 1'b1;
                        n_fill_cnt          = r_fill_cnt + 1'b1;
                        n_res.done          = 1'b1;
                        n_res.filled        = 1'b1;
                        n_res.line          = IDX_W'(first_free);
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                mem_re    = !r_issue_done;
                n_cmp_vld = !r_issue_done;
                if (!r_issue_done) begin
                    n_addr = r_addr + 1'b1;
                    if (r_addr == LAST) begin
                        n_issue_done = 1'b1;
                    end
                end
                if (r_cmp_vld) begin
                    if (r_cmd == CMD_LOOKUP) begin
                        if (match) begin
                            n_state    = S_IDLE;
                            n_res.done = 1'b1;
                            n_res.hit  = 1'b1;
                            n_res.line = IDX_W'(r_cmp_idx);
                            n_res.len  = mem_rdata.len;
                        end else if (r_cmp_idx == LAST) begin
                            n_state    = S_IDLE;
                            n_res.done = 1'b1;
                        end
                    end else begin
                        if (older) begin
                            n_min_stamp = mem_rdata.stamp;
                            n_min_idx   = r_cmp_idx;
                        end
                        if (r_cmp_idx == LAST) begin
                            mem_we             = 1'b1;
                            mem_waddr          = n_min_idx;
                            mem_wdata          = '{tag: r_key, len: r_len,
                                                   stamp: r_fill_cnt + 1'b1};
                            n_valid[n_min_idx] = 1'b1;
                            n_fill_cnt         = r_fill_cnt + 1'b1;
                            n_state            = S_IDLE;
                            n_res.done         = 1'b1;
                            n_res.filled       = 1'b1;
                            n_res.line         = IDX_W'(n_min_idx);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_fill_cnt <= '0;
            r_cmp_vld  <= 1'b0;
            r_res      <= '0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_fill_cnt <= n_fill_cnt;
            r_cmp_vld  <= n_cmp_vld;
            r_res      <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_len        <= n_len;
        r_addr       <= n_addr;
        r_issue_done <= n_issue_done;
        r_cmp_idx    <= n_cmp_idx;
        r_min_stamp  <= n_min_stamp;
        r_min_idx    <= n_min_idx;
    end

    assign o_res = r_res;

endmodule

// ===== hdl/object_cache_tag_store_core.sv =====
// ----------------------------------------------------------------------------
// object_cache_tag_store_core
// Fully associative tag store with oldest-fill replacement.
// Lookup walks the lines, one line memory read per cycle, and ends on the first
//   match or after the last line; a fill into a free line or an oversized fill
//   answers in the cycle after it is taken; a full-cache fill first walks all stamps.
// Throughput: one command at a time; a walk holds busy high up to the result
//   strobe cycle, a free-line or oversized fill never raises it.
// Reset: synchronous active low, clears valid bits and fill counter, sets the
//   size limit to 102400. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module object_cache_tag_store_core
    import octs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_cmd,
    input  logic [KEY_W-1:0] i_key,
    input  logic [LEN_W-1:0] i_object_length,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    output logic             o_done,
    output logic             o_hit,
    output logic [IDX_W-1:0] o_line_index,
    output logic [LEN_W-1:0] o_stored_length,
    output logic             o_filled
);

    logic [LEN_W-1:0] r_max_obj;
    t_cmd             cmd;
    t_result          res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_obj <= MAX_OBJ_RESET;
        end else if (i_cfg_we) begin
            r_max_obj <= i_cfg_wdata;
        end
    end

    // command beat
    assign cmd = '{start: start, cmd: i_cmd, key: i_key, len: i_object_length};

    octs_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_max_obj (r_max_obj),
        .o_busy    (busy),
        .o_res     (res)
    );

    assign o_done          = res.done;
    assign o_hit           = res.hit;
    assign o_line_index    = res.line;
    assign o_stored_length = res.len;
    assign o_filled        = res.filled;

endmodule
